@@ hw/rtl/sph_pkg.sv @@
// Shared types and constants for the segment proximity hit test.
// No dependencies; sph_geom, sph_classify, sph_cmp, the top level and the testbench import it.
package sph_pkg;

  localparam int THR_BITS   = 8;
  localparam int THR2_BITS  = 2 * THR_BITS;
  localparam logic [THR_BITS-1:0] THR_RESET = 8'd5;

  // Which distance decides an item that does not sit on an endpoint.
  typedef enum logic [1:0] {
    REGION_START,
    REGION_END,
    REGION_PERP
  } region_e;

  // Per-item decision state handed from the classifier to the comparator.
  typedef struct packed {
    logic    coinc;   // probe sits exactly on an endpoint
    region_e region;
    logic    ep_cmp;  // squared endpoint distance below squared threshold
  } cls_t;

endpackage

@@ hw/rtl/sph_if.sv @@
// Valid/ready channel interfaces for the segment proximity hit test.
// Input channel carries probe and segment coordinates; output carries the hit flag.
interface sph_in_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] probe_x;
  logic signed [COORD_BITS-1:0] probe_y;
  logic signed [COORD_BITS-1:0] seg_start_x;
  logic signed [COORD_BITS-1:0] seg_start_y;
  logic signed [COORD_BITS-1:0] seg_end_x;
  logic signed [COORD_BITS-1:0] seg_end_y;

  modport source (
    output valid, probe_x, probe_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    input  ready
  );
  modport sink (
    input  valid, probe_x, probe_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    output ready
  );
endinterface

interface sph_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

@@ hw/rtl/sph_geom.sv @@
// Geometry front end: differences, products and dot/cross sums (three stages).
// Depends on sph_pkg.
module sph_geom import sph_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [COORD_BITS-1:0]  px_i,
  input  logic signed [COORD_BITS-1:0]  py_i,
  input  logic signed [COORD_BITS-1:0]  ax_i,
  input  logic signed [COORD_BITS-1:0]  ay_i,
  input  logic signed [COORD_BITS-1:0]  bx_i,
  input  logic signed [COORD_BITS-1:0]  by_i,
  input  logic [THR_BITS-1:0]           thr_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic                          coinc_o,
  output logic [THR2_BITS-1:0]          thr2_o,
  output logic signed [2*COORD_BITS+2:0] va2_o,
  output logic signed [2*COORD_BITS+2:0] wb2_o,
  output logic signed [2*COORD_BITS+2:0] len2_o,
  output logic signed [2*COORD_BITS+2:0] t_o,
  output logic signed [2*COORD_BITS+2:0] cr_o
);

  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D;
  localparam int S = P + 1;

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  // stage 1: differences
  logic signed [D-1:0] vx_d, vy_d, wx_d, wy_d, dx_d, dy_d;
  logic signed [D-1:0] vx_q, vy_q, wx_q, wy_q, dx_q, dy_q;
  logic                coinc_d, coinc1_q, coinc2_q, coinc3_q;
  logic [THR_BITS-1:0] thr1_q;

  // stage 2: products
  logic signed [P-1:0] pvx_q, pvy_q, pwx_q, pwy_q, pdx_q, pdy_q;
  logic signed [P-1:0] pvxdx_q, pvydy_q, pvxdy_q, pvydx_q;
  logic [THR2_BITS-1:0] thr2a_q, thr2b_q;

  // stage 3: sums
  logic signed [S-1:0] va2_q, wb2_q, len2_q, t_q, cr_q;

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v3_q;

  assign vx_d = $signed({px_i[COORD_BITS-1], px_i}) - $signed({ax_i[COORD_BITS-1], ax_i});
  assign vy_d = $signed({py_i[COORD_BITS-1], py_i}) - $signed({ay_i[COORD_BITS-1], ay_i});
  assign wx_d = $signed({px_i[COORD_BITS-1], px_i}) - $signed({bx_i[COORD_BITS-1], bx_i});
  assign wy_d = $signed({py_i[COORD_BITS-1], py_i}) - $signed({by_i[COORD_BITS-1], by_i});
  assign dx_d = $signed({bx_i[COORD_BITS-1], bx_i}) - $signed({ax_i[COORD_BITS-1], ax_i});
  assign dy_d = $signed({by_i[COORD_BITS-1], by_i}) - $signed({ay_i[COORD_BITS-1], ay_i});
  assign coinc_d = ((px_i == ax_i) && (py_i == ay_i)) || ((px_i == bx_i) && (py_i == by_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      vx_q     <= vx_d;
      vy_q     <= vy_d;
      wx_q     <= wx_d;
      wy_q     <= wy_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      coinc1_q <= coinc_d;
      thr1_q   <= thr_i;
    end
    if (en2 && v1_q) begin
      pvx_q    <= P'(vx_q) * P'(vx_q);
      pvy_q    <= P'(vy_q) * P'(vy_q);
      pwx_q    <= P'(wx_q) * P'(wx_q);
      pwy_q    <= P'(wy_q) * P'(wy_q);
      pdx_q    <= P'(dx_q) * P'(dx_q);
      pdy_q    <= P'(dy_q) * P'(dy_q);
      pvxdx_q  <= P'(vx_q) * P'(dx_q);
      pvydy_q  <= P'(vy_q) * P'(dy_q);
      pvxdy_q  <= P'(vx_q) * P'(dy_q);
      pvydx_q  <= P'(vy_q) * P'(dx_q);
      thr2a_q  <= THR2_BITS'(thr1_q) * THR2_BITS'(thr1_q);
      coinc2_q <= coinc1_q;
    end
    if (en3 && v2_q) begin
      va2_q    <= S'(pvx_q) + S'(pvy_q);
      wb2_q    <= S'(pwx_q) + S'(pwy_q);
      len2_q   <= S'(pdx_q) + S'(pdy_q);
      t_q      <= S'(pvxdx_q) + S'(pvydy_q);
      cr_q     <= S'(pvxdy_q) - S'(pvydx_q);
      thr2b_q  <= thr2a_q;
      coinc3_q <= coinc2_q;
    end
  end

  assign coinc_o = coinc3_q;
  assign thr2_o  = thr2b_q;
  assign va2_o   = va2_q;
  assign wb2_o   = wb2_q;
  assign len2_o  = len2_q;
  assign t_o     = t_q;
  assign cr_o    = cr_q;

endmodule

@@ hw/rtl/sph_classify.sv @@
// Region classifier: picks endpoint or perpendicular case, endpoint compare, |cross|.
// Depends on sph_pkg.
module sph_classify import sph_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic                           coinc_i,
  input  logic [THR2_BITS-1:0]           thr2_i,
  input  logic signed [2*COORD_BITS+2:0] va2_i,
  input  logic signed [2*COORD_BITS+2:0] wb2_i,
  input  logic signed [2*COORD_BITS+2:0] len2_i,
  input  logic signed [2*COORD_BITS+2:0] t_i,
  input  logic signed [2*COORD_BITS+2:0] cr_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output cls_t                           cls_o,
  output logic [THR2_BITS-1:0]           thr2_o,
  output logic [2*COORD_BITS+2:0]        len2_o,
  output logic [2*COORD_BITS+2:0]        crm_o
);

  localparam int S = 2 * (COORD_BITS + 1) + 1;

  logic en;
  logic v_q;
  logic near, far;
  logic start_lt, end_lt;
  cls_t cls_d, cls_q;
  logic [S-1:0] crm_d, crm_q, len2_q;
  logic [THR2_BITS-1:0] thr2_q;

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;

  // Squares are never negative, so unsigned compares are exact.
  assign near     = (len2_i == '0) || (t_i <= $signed(S'(0)));
  assign far      = (t_i >= len2_i);
  assign start_lt = $unsigned(va2_i) < S'(thr2_i);
  assign end_lt   = $unsigned(wb2_i) < S'(thr2_i);
  assign crm_d    = cr_i[S-1] ? $unsigned(-cr_i) : $unsigned(cr_i);

  always_comb begin
    cls_d.coinc = coinc_i;
    if (near) begin
      cls_d.region = REGION_START;
      cls_d.ep_cmp = start_lt;
    end else if (far) begin
      cls_d.region = REGION_END;
      cls_d.ep_cmp = end_lt;
    end else begin
      cls_d.region = REGION_PERP;
      cls_d.ep_cmp = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      cls_q  <= cls_d;
      crm_q  <= crm_d;
      len2_q <= $unsigned(len2_i);
      thr2_q <= thr2_i;
    end
  end

  assign cls_o  = cls_q;
  assign crm_o  = crm_q;
  assign len2_o = len2_q;
  assign thr2_o = thr2_q;

endmodule

@@ hw/rtl/sph_cmp.sv @@
// Wide compare cross^2 < T^2 * |d|^2 via split partial products, plus output register.
// Depends on sph_pkg.
module sph_cmp import sph_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  cls_t                    cls_i,
  input  logic [THR2_BITS-1:0]    thr2_i,
  input  logic [2*COORD_BITS+2:0] len2_i,
  input  logic [2*COORD_BITS+2:0] crm_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic                    hit_o
);

  localparam int S  = 2 * (COORD_BITS + 1) + 1;
  localparam int H  = (S + 1) / 2;
  localparam int HI = S - H;
  localparam int LW = 2 * S;

  logic en5, en6, en7;
  logic v5_q, v6_q, v7_q;
  cls_t cls5_q, cls6_q;

  logic [2*HI-1:0]         hh_q;
  logic [H+HI-1:0]         hl_q;
  logic [2*H-1:0]          ll_q;
  logic [THR2_BITS+HI-1:0] th_q;
  logic [THR2_BITS+H-1:0]  tl_q;
  logic [LW-1:0]           lhs_q, rhs_q;
  logic                    hit_d, hit_q;

  assign en7     = !v7_q || ready_i;
  assign en6     = !v6_q || en7;
  assign en5     = !v5_q || en6;
  assign ready_o = en5;
  assign valid_o = v7_q;

  always_comb begin
    unique case (cls6_q.region)
      REGION_PERP: hit_d = cls6_q.coinc || (lhs_q < rhs_q);
      default:     hit_d = cls6_q.coinc || cls6_q.ep_cmp;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en5) v5_q <= valid_i;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && valid_i) begin
      hh_q   <= (2*HI)'(crm_i[S-1:H]) * (2*HI)'(crm_i[S-1:H]);
      hl_q   <= (H+HI)'(crm_i[S-1:H]) * (H+HI)'(crm_i[H-1:0]);
      ll_q   <= (2*H)'(crm_i[H-1:0]) * (2*H)'(crm_i[H-1:0]);
      th_q   <= (THR2_BITS+HI)'(thr2_i) * (THR2_BITS+HI)'(len2_i[S-1:H]);
      tl_q   <= (THR2_BITS+H)'(thr2_i) * (THR2_BITS+H)'(len2_i[H-1:0]);
      cls5_q <= cls_i;
    end
    if (en6 && v5_q) begin
      lhs_q  <= (LW'(hh_q) << (2 * H)) + (LW'(hl_q) << (H + 1)) + LW'(ll_q);
      rhs_q  <= (LW'(th_q) << H) + LW'(tl_q);
      cls6_q <= cls5_q;
    end
    if (en7 && v6_q) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

@@ hw/rtl/segment_proximity_hit_test_top.sv @@
// Top level of the segment proximity hit test: threshold register and pipeline.
// Depends on sph_pkg, sph_if, sph_geom, sph_classify and sph_cmp.
//
// Usage:
//   in_i  (valid/ready) carries one item: probe point P and segment endpoints
//         A and B, each coordinate COORD_BITS wide, two's complement.
//   out_o (valid/ready) returns one item per input item, in order: hit is 1
//         when P lies strictly closer than select_distance to segment AB, or
//         sits exactly on A or B.
//   cfg_we_i / cfg_wdata_i write select_distance (pixels); write only while
//         the pipeline is empty.
// Pipeline: three geometry stages, one classify stage, three compare stages
//   ending in the output register.
// Throughput: one item per cycle while out_o.ready is high; the wide cross-product square is cut into
//   half-width partial products so every stage holds one multiply or add.
// Reset: rst_ni clears all pipeline valid bits and loads select_distance with
//   5; no item is in flight afterwards and in_i.ready rises at once.
// Stall: when out_o.ready is low, the stages fill up behind the output
//   register, closing bubbles; in_i.ready drops only once every stage holds
//   an item. Nothing is lost or repeated.
module segment_proximity_hit_test_top import sph_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [THR_BITS-1:0] cfg_wdata_i,
  sph_in_if.sink              in_i,
  sph_out_if.source           out_o
);

  localparam int S = 2 * (COORD_BITS + 1) + 1;

  logic [THR_BITS-1:0] select_distance_q;

  // geometry -> classifier
  logic                g_valid, g_ready, g_coinc;
  logic [THR2_BITS-1:0] g_thr2;
  logic signed [S-1:0] g_va2, g_wb2, g_len2, g_t, g_cr;

  // classifier -> comparator
  logic                c_valid, c_ready;
  cls_t                c_cls;
  logic [THR2_BITS-1:0] c_thr2;
  logic [S-1:0]        c_len2, c_crm;

  logic in_ready;

  // Threshold register: load on write enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_distance_q <= THR_RESET;
    end else if (cfg_we_i) begin
      select_distance_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = in_ready;

  sph_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_ready),
    .px_i    (in_i.probe_x),
    .py_i    (in_i.probe_y),
    .ax_i    (in_i.seg_start_x),
    .ay_i    (in_i.seg_start_y),
    .bx_i    (in_i.seg_end_x),
    .by_i    (in_i.seg_end_y),
    .thr_i   (select_distance_q),
    .valid_o (g_valid),
    .ready_i (g_ready),
    .coinc_o (g_coinc),
    .thr2_o  (g_thr2),
    .va2_o   (g_va2),
    .wb2_o   (g_wb2),
    .len2_o  (g_len2),
    .t_o     (g_t),
    .cr_o    (g_cr)
  );

  sph_classify #(.COORD_BITS(COORD_BITS)) u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_valid),
    .ready_o (g_ready),
    .coinc_i (g_coinc),
    .thr2_i  (g_thr2),
    .va2_i   (g_va2),
    .wb2_i   (g_wb2),
    .len2_i  (g_len2),
    .t_i     (g_t),
    .cr_i    (g_cr),
    .valid_o (c_valid),
    .ready_i (c_ready),
    .cls_o   (c_cls),
    .thr2_o  (c_thr2),
    .len2_o  (c_len2),
    .crm_o   (c_crm)
  );

  sph_cmp #(.COORD_BITS(COORD_BITS)) u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid),
    .ready_o (c_ready),
    .cls_i   (c_cls),
    .thr2_i  (c_thr2),
    .len2_i  (c_len2),
    .crm_i   (c_crm),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .hit_o   (out_o.hit)
  );

`ifndef SYNTHESIS
  // Input back-pressure can only come from a blocked output register.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without a blocked output");

  // An empty output register always leaves the input open.
  a_empty_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_ready)
    else $error("input closed while output register empty");

  // Threshold changes only through a write.
  a_thr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(select_distance_q))
    else $error("threshold changed without a write");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for segment_proximity_hit_test_top: directed and random probe/segment items,
// each checked against an exact integer hit predictor kept in a small scoreboard class.
// Depends on sph_pkg, sph_if and the block's RTL; reads nothing from outside.
module tb_top;
  import sph_pkg::*;

  localparam int CW          = 16;    // coordinate width, matches the block default
  localparam int QUIET_LIMIT = 4000;  // cycles without any handshake before giving up
  localparam int PHASE_ITEMS = 258;   // random items per threshold setting
  localparam int HOLD_CYCLES = 60;    // long receiver hold-off, well past pipeline depth

  // One input item: probe point and both segment endpoints.
  typedef struct packed {
    logic signed [CW-1:0] probe_x;
    logic signed [CW-1:0] probe_y;
    logic signed [CW-1:0] seg_start_x;
    logic signed [CW-1:0] seg_start_y;
    logic signed [CW-1:0] seg_end_x;
    logic signed [CW-1:0] seg_end_y;
  } seg_query_t;

  // Holds the expected hit flags in arrival order, together with a private copy
  // of the threshold register used to work them out.
  class hit_scoreboard;
    bit                  pending_hits[$];
    logic [THR_BITS-1:0] threshold;
    int unsigned         mismatches;

    function new();
      threshold  = THR_RESET;
      mismatches = 0;
    endfunction

    function void set_threshold(logic [THR_BITS-1:0] value);
      threshold = value;
    endfunction

    // Exact squared-distance test; 64 bits cover every term except the
    // squared cross product against threshold^2 * |d|^2.
    function bit predict_hit(seg_query_t q);
      longint px, py, ax, ay, bx, by;
      longint vx, vy, wx, wy, dx, dy;
      longint thr, thr2, near_a2, near_b2, len2, along, across;
      logic signed [127:0] across_w, across2, limit2;
      px = $signed(q.probe_x);
      py = $signed(q.probe_y);
      ax = $signed(q.seg_start_x);
      ay = $signed(q.seg_start_y);
      bx = $signed(q.seg_end_x);
      by = $signed(q.seg_end_y);
      // Probe on either endpoint always hits, whatever the threshold.
      if ((px == ax && py == ay) || (px == bx && py == by)) return 1'b1;
      vx = px - ax;
      vy = py - ay;
      wx = px - bx;
      wy = py - by;
      dx = bx - ax;
      dy = by - ay;
      thr     = threshold;
      thr2    = thr * thr;
      near_a2 = vx * vx + vy * vy;
      near_b2 = wx * wx + wy * wy;
      len2    = dx * dx + dy * dy;
      along   = vx * dx + vy * dy;
      across  = vx * dy - vy * dx;
      // Degenerate segment, or projection at or before the start point.
      if (len2 == 0 || along <= 0) return near_a2 < thr2;
      // Projection at or beyond the end point.
      if (along >= len2) return near_b2 < thr2;
      across_w = across;
      across2  = across_w * across_w;
      limit2   = thr2 * len2;
      return across2 < limit2;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task note_item(seg_query_t q);
      pending_hits.push_back(predict_hit(q));
    endtask

    task check_result(logic got);
      bit want;
      if (pending_hits.size() == 0) begin
        report($sformatf("hit=%b arrived with no item outstanding", got));
        return;
      end
      want = pending_hits.pop_front();
      if (got !== want) report($sformatf("hit expected %0b, got %b", want, got));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [THR_BITS-1:0] cfg_wdata_i;

  sph_in_if #(.COORD_BITS(CW)) in_if ();
  sph_out_if                   out_if ();

  hit_scoreboard sb = new();

  // Knobs shared between the stimulus thread and the receiver.
  bit          tx_gaps_on;
  bit          rx_stalls_on;
  int          hold_asks;
  int          holds_done;
  int          hold_left;
  int          stall_left;
  int unsigned quiet_cycles;
  seg_query_t  seen_query;

  segment_proximity_hit_test_top #(.COORD_BITS(CW)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Monitor and watchdog: sample both channels at the rising edge, before any
  // of this edge's nonblocking updates land, so no ordering race can creep in.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        seen_query.probe_x     = in_if.probe_x;
        seen_query.probe_y     = in_if.probe_y;
        seen_query.seg_start_x = in_if.seg_start_x;
        seen_query.seg_start_y = in_if.seg_start_y;
        seen_query.seg_end_x   = in_if.seg_end_x;
        seen_query.seg_end_y   = in_if.seg_end_y;
        sb.note_item(seen_query);
      end
      if (out_if.valid && out_if.ready) sb.check_result(out_if.hit);
      // Count only cycles in which neither side moves an item.
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: a requested long hold-off wins, then any running stall burst,
  // otherwise start a fresh burst now and then.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one item and hold it until the block takes it. Valid stays high on
  // return so back-to-back items need no second assignment in the same step.
  task automatic send_query(seg_query_t q);
    in_if.valid       <= 1'b1;
    in_if.probe_x     <= q.probe_x;
    in_if.probe_y     <= q.probe_y;
    in_if.seg_start_x <= q.seg_start_x;
    in_if.seg_start_y <= q.seg_start_y;
    in_if.seg_end_x   <= q.seg_end_x;
    in_if.seg_end_y   <= q.seg_end_y;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic probe_segment(int px, int py, int ax, int ay, int bx, int by);
    seg_query_t q;
    q.probe_x     = CW'(px);
    q.probe_y     = CW'(py);
    q.seg_start_x = CW'(ax);
    q.seg_start_y = CW'(ay);
    q.seg_end_x   = CW'(bx);
    q.seg_end_y   = CW'(by);
    send_query(q);
  endtask

  // Drop valid, let the monitor log the last item, drain the pipeline, then
  // write the threshold on an idle block.
  task automatic set_threshold_reg(logic [THR_BITS-1:0] value);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_hits.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_threshold(value);
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rand_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Most items sit a threshold's width around a segment of random scale, so
  // hits and misses both come often; the rest cover endpoints, degenerate
  // segments, projections landing exactly on an end, and raw noise.
  function automatic seg_query_t random_query(int thr);
    seg_query_t q;
    int px, py, ax, ay, bx, by, dx, dy;
    int span, reach, f, k, kind;
    kind  = $urandom_range(0, 99);
    reach = thr + 4;
    case ($urandom_range(0, 3))
      0:       span = 8;
      1:       span = 300;
      2:       span = 4000;
      default: span = 32767;
    endcase
    ax = rand_coord();
    ay = rand_coord();
    dx = rand_span(span);
    dy = rand_span(span);
    bx = ax + dx;
    by = ay + dy;
    // Walk from a quarter before the start to a quarter past the end.
    f  = int'($urandom_range(0, 24)) - 4;
    px = ax + dx * f / 16 + rand_span(reach);
    py = ay + dy * f / 16 + rand_span(reach);
    if (kind < 10) begin
      px = rand_coord();
      py = rand_coord();
      bx = rand_coord();
      by = rand_coord();
    end else if (kind < 20) begin
      if ($urandom_range(0, 1) != 0) begin
        px = ax;
        py = ay;
      end else begin
        px = bx;
        py = by;
      end
    end else if (kind < 28) begin
      bx = ax;
      by = ay;
      px = ax + rand_span(reach);
      py = ay + rand_span(reach);
    end else if (kind < 38) begin
      // Step square off one end so the projection falls exactly on it.
      dx = rand_span(24);
      dy = rand_span(24);
      bx = ax + dx;
      by = ay + dy;
      k  = rand_span(3);
      if ($urandom_range(0, 1) != 0) begin
        px = ax - k * dy;
        py = ay + k * dx;
      end else begin
        px = bx - k * dy;
        py = by + k * dx;
      end
    end
    q.probe_x     = CW'(px);
    q.probe_y     = CW'(py);
    q.seg_start_x = CW'(ax);
    q.seg_start_y = CW'(ay);
    q.seg_end_x   = CW'(bx);
    q.seg_end_y   = CW'(by);
    return q;
  endfunction

  // Stimulus thread.
  initial begin
    int thr;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    in_if.valid        <= 1'b0;
    in_if.probe_x      <= '0;
    in_if.probe_y      <= '0;
    in_if.seg_start_x  <= '0;
    in_if.seg_start_y  <= '0;
    in_if.seg_end_x    <= '0;
    in_if.seg_end_y    <= '0;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b1;
    hold_asks    = 0;
    holds_done   = 0;
    hold_left    = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items at the reset threshold of 5 pixels.
    probe_segment(0, 0, 0, 0, 100, 0);                 // on the start point
    probe_segment(100, 0, 0, 0, 100, 0);               // on the end point
    probe_segment(-32768, -32768, 32767, 32767, -32768, 32767);
    probe_segment(32767, 32767, -32768, -32768, 32767, -32768);
    probe_segment(0, 1, -32768, -32768, 32767, 32767); // beside the full diagonal
    probe_segment(-32768, 32767, -32768, -32768, 32767, 32767); // widest cross product
    probe_segment(13, 14, 10, 10, 10, 10);             // degenerate, exactly 5 away
    probe_segment(13, 13, 10, 10, 10, 10);             // degenerate, inside
    probe_segment(50, 4, 0, 0, 100, 0);                // perpendicular, inside
    probe_segment(50, 5, 0, 0, 100, 0);                // perpendicular, on the limit
    probe_segment(50, -4, 0, 0, 100, 0);
    probe_segment(103, 3, 0, 0, 100, 0);               // past the end
    probe_segment(104, 3, 0, 0, 100, 0);
    probe_segment(-3, 4, 0, 0, 100, 0);                // before the start
    probe_segment(-3, 3, 0, 0, 100, 0);
    probe_segment(4, 0, 0, 0, 0, 100);                 // projection exactly on the start
    probe_segment(5, 0, 0, 0, 0, 100);
    probe_segment(-4, 100, 0, 0, 0, 100);              // projection exactly on the end

    // Zero threshold: only an endpoint coincidence may hit.
    set_threshold_reg(8'd0);
    probe_segment(0, 0, 0, 0, 100, 0);
    probe_segment(50, 0, 0, 0, 100, 0);
    probe_segment(-32768, -32768, 0, 0, -32768, -32768);

    // Widest threshold.
    set_threshold_reg(8'd255);
    probe_segment(50, 254, 0, 0, 100, 0);
    probe_segment(50, 255, 0, 0, 100, 0);
    probe_segment(-180, -180, 0, 0, 0, 100);

    // Random phases, each under its own threshold and idling pattern. The
    // last phase runs flat out on both sides.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       thr = 1;
        1:       thr = $urandom_range(2, 254);
        2:       thr = 255;
        3:       thr = 0;
        4:       thr = $urandom_range(0, 255);
        default: thr = 5;
      endcase
      set_threshold_reg(THR_BITS'(thr));
      tx_gaps_on   = (ph != 1) && (ph != 5);
      rx_stalls_on = (ph != 2) && (ph != 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the receiver off while items keep coming, to fill the pipeline.
        if (ph == 1 && n == 40) hold_asks++;
        if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
          in_if.valid <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk_i);
        end
        send_query(random_query(thr));
      end
    end

    // Drain, then allow a pipeline's worth of cycles for any stray result.
    in_if.valid <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
